// ===== rtl/core/learning_bridge_forward_decision_defines.svh =====
// ---------------------------------------------------------------------------
// Learning bridge assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef LEARNING_BRIDGE_FORWARD_DECISION_DEFINES_SVH
`define LEARNING_BRIDGE_FORWARD_DECISION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define LBFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lbfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Learning bridge package
// Beat types, register indexes, verdict codes and port constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbfd_pkg;

  // Field widths
  localparam int PORT_W   = 3;
  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int MASK_W   = 8;
  localparam int VERD_W   = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  // Group bit: lsb of the first address byte
  localparam int GROUP_BIT = 40;

  // Ports that exist: those below both NUM_PORTS and the mask width
  localparam int NUM_PORTS  = 8;
  localparam int LIVE_PORTS = (NUM_PORTS < MASK_W) ? NUM_PORTS : MASK_W;
  localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((9'd1 << LIVE_PORTS) - 9'd1);

  // Register reset values
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd300;
  localparam logic [MASK_W-1:0] ENABLE_RST  = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AGE_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLE = 4'd1;

  // Verdict codes
  localparam logic [VERD_W-1:0] VERD_FORWARD     = 3'd0;
  localparam logic [VERD_W-1:0] VERD_FLOOD       = 3'd1;
  localparam logic [VERD_W-1:0] VERD_IN_DISABLED = 3'd2;
  localparam logic [VERD_W-1:0] VERD_SAME_PORT   = 3'd3;
  localparam logic [VERD_W-1:0] VERD_OUT_DISABLED = 3'd4;

  typedef struct packed {
    logic [PORT_W-1:0] ingress_port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [TIME_W-1:0] arrival_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic [VERD_W-1:0] verdict;
    logic              learn_skipped;
  } out_beat_t;

endpackage

// ===== rtl/core/learning_bridge_forward_decision.sv =====
// Learning bridge forwarding decision. Each input beat is one frame header;
// each produces exactly one decision beat. The MAC table is a fully
// associative array of TABLE_ENTRIES entries in flip-flops: source and
// destination are matched against every entry in parallel, the source is
// learned or refreshed and an expired destination is erased in the same
// cycle the decision is formed. One header is taken per clock while the output
// does not stall; each passes the input register, then the decision register,
// with the table compare between them. Valid bits clear at reset, so the block
// takes headers right after reset.
`timescale 1ns / 1ps
`include "learning_bridge_forward_decision_defines.svh"

// ---------------------------------------------------------------------------
// learning_bridge_forward_decision
// MAC learning, aging and per-frame egress decision with a parallel table.
// ---------------------------------------------------------------------------
module learning_bridge_forward_decision
  import lbfd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // header input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  // decision output
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // configuration registers
  logic [TMO_W-1:0]  timeout_r;
  logic [MASK_W-1:0] enable_r;

  // pipeline registers
  logic      s1_valid_r;
  in_beat_t  s1_data_r;
  logic      out_valid_r;
  out_beat_t out_data_r;

  // table
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [MAC_W-1:0]         mac_r   [TABLE_ENTRIES];
  logic [PORT_W-1:0]        port_r  [TABLE_ENTRIES];
  logic [TIME_W-1:0]        stamp_r [TABLE_ENTRIES];

  // decision logic
  logic                     move;
  logic [MASK_W-1:0]        enabled;
  logic                     ing_ok;
  logic                     learn_on;
  logic [TABLE_ENTRIES-1:0] src_hit;
  logic [TABLE_ENTRIES-1:0] dst_hit;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [TABLE_ENTRIES-1:0] wr_oh;
  logic [TABLE_ENTRIES-1:0] clr_oh;
  logic                     src_found;
  logic                     dst_found;
  logic                     full;
  logic                     skipped;
  logic                     same_mac;
  logic                     lookup;
  logic [PORT_W-1:0]        dst_port;
  logic [TIME_W-1:0]        dst_stamp;
  logic [TIME_W:0]          limit;
  logic                     live;
  logic                     have_out;
  logic                     expire;
  logic [PORT_W-1:0]        outport;
  logic [MASK_W-1:0]        ing_bit;
  logic [MASK_W-1:0]        out_bit;
  out_beat_t                result;

  // config port always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      enable_r  <= ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AGE_TIMEOUT: timeout_r <= cfg_data;
        REG_PORT_ENABLE: enable_r  <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the header into the decision register when the output frees
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // parallel match against every entry
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      src_hit[i] = valid_r[i] && (mac_r[i] == s1_data_r.src_mac);
      dst_hit[i] = valid_r[i] && (mac_r[i] == s1_data_r.dst_mac);
    end
  end

  // read out the destination entry through its one-hot match
  always_comb begin
    dst_port  = '0;
    dst_stamp = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      dst_port  = dst_port  | (port_r[i]  & {PORT_W{dst_hit[i]}});
      dst_stamp = dst_stamp | (stamp_r[i] & {TIME_W{dst_hit[i]}});
    end
  end

  // lowest free slot: isolate the lowest set bit of the invalid vector
  assign free_vec  = ~valid_r;
  assign free_oh   = free_vec & (~free_vec + TABLE_ENTRIES'(1));
  assign full      = &valid_r;
  assign src_found = |src_hit;
  assign dst_found = |dst_hit;

  assign enabled  = enable_r & LIVE_MASK;
  assign ing_bit  = MASK_W'(1) << s1_data_r.ingress_port;
  assign ing_ok   = |(enabled & ing_bit);
  assign learn_on = ing_ok && (timeout_r != '0);
  assign skipped  = learn_on && !src_found && full;
  assign wr_oh    = (learn_on && !skipped) ? (src_found ? src_hit : free_oh) : '0;

  // destination lookup; a self-addressed frame sees its own refreshed entry
  assign same_mac = s1_data_r.dst_mac == s1_data_r.src_mac;
  assign lookup   = learn_on && !s1_data_r.dst_mac[GROUP_BIT];
  assign limit    = {1'b0, dst_stamp} + (TIME_W+1)'(timeout_r);
  assign live     = {1'b0, s1_data_r.arrival_seconds} < limit;
  assign expire   = lookup && !same_mac && dst_found && !live;
  assign clr_oh   = expire ? dst_hit : '0;

  always_comb begin
    if (same_mac) begin
      have_out = lookup && !skipped;
      outport  = s1_data_r.ingress_port;
    end else begin
      have_out = lookup && dst_found && live;
      outport  = dst_port;
    end
  end

  assign out_bit = MASK_W'(1) << outport;

  // form the decision
  always_comb begin
    result.egress_mask   = '0;
    result.learn_skipped = skipped;
    if (!ing_ok) begin
      result.verdict = VERD_IN_DISABLED;
    end else if (!have_out) begin
      result.egress_mask = enabled & ~ing_bit;
      result.verdict     = VERD_FLOOD;
    end else if (outport == s1_data_r.ingress_port) begin
      result.verdict = VERD_SAME_PORT;
    end else if (!(|(enabled & out_bit))) begin
      result.verdict = VERD_OUT_DISABLED;
    end else begin
      result.egress_mask = out_bit;
      result.verdict     = VERD_FORWARD;
    end
  end

  // update valid bits: set on learn, drop on expiry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (move) begin
      valid_r <= (valid_r | wr_oh) & ~clr_oh;
    end
  end

  // write learned address, port and stamp
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (move && wr_oh[i]) begin
        mac_r[i]   <= s1_data_r.src_mac;
        port_r[i]  <= s1_data_r.ingress_port;
        stamp_r[i] <= s1_data_r.arrival_seconds;
      end
    end
  end

  // decision register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // each address sits in at most one entry
  `LBFD_ASSERT_NOW(a_src_unique, s1_valid_r, $onehot0(src_hit), "duplicate source entry")
  `LBFD_ASSERT_NOW(a_dst_unique, s1_valid_r, $onehot0(dst_hit), "duplicate destination entry")
  // a forwarded frame leaves on exactly one port
  `LBFD_ASSERT_NOW(a_fwd_onehot, out_valid_r && (out_data_r.verdict == VERD_FORWARD),
                   $onehot(out_data_r.egress_mask), "forward mask not one-hot")
  // after a learn, the table holds at least one valid entry on the next cycle
  `LBFD_ASSERT_NEXT(a_learned, move && learn_on && !skipped && !expire,
                    $countones(valid_r) != 0, "learned source missing")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// Learning bridge forwarding decision testbench
// Drives frame headers through the bridge under several register settings and
// idle patterns. A local MAC-table model predicts each decision beat, and every
// output beat is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  import lbfd_pkg::*;

  localparam int       TBL         = 64;
  localparam int       POOL        = 96;
  localparam int       SETTLE      = 4;
  localparam longint   CYCLE_LIMIT = 500000;

  localparam logic [MAC_W-1:0] MAC_A     = 48'h0200_0000_00A1;
  localparam logic [MAC_W-1:0] MAC_B     = 48'h0200_0000_00B2;
  localparam logic [MAC_W-1:0] MAC_C     = 48'h0A00_0000_00C3;
  localparam logic [MAC_W-1:0] MAC_D     = 48'h0C00_0000_00D4;
  localparam logic [MAC_W-1:0] MAC_E     = 48'h0E00_0000_00E5;
  localparam logic [MAC_W-1:0] MAC_F     = 48'h5400_0000_00F6;
  localparam logic [MAC_W-1:0] MAC_HI    = 48'hFEFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_GROUP = 48'h0100_5E00_0001;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // MAC table model and register copies
  logic [MAC_W-1:0]  tbl_mac   [TBL];
  logic [PORT_W-1:0] tbl_port  [TBL];
  logic [TIME_W-1:0] tbl_stamp [TBL];
  bit                tbl_valid [TBL];
  logic [TMO_W-1:0]  cur_timeout;
  logic [MASK_W-1:0] cur_enable;

  out_beat_t pending_decisions[$];
  out_beat_t want;

  // Station pool for well-formed traffic
  logic [MAC_W-1:0]  host_mac  [POOL];
  logic [PORT_W-1:0] host_port [POOL];
  logic [TIME_W-1:0] clock_s;

  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  int     err_cnt = 0;
  int     frames_sent = 0;
  int     n_forward = 0;
  int     n_flood = 0;
  int     n_drop = 0;
  int     n_skip = 0;
  longint cycle_count = 0;

  learning_bridge_forward_decision #(
    .TABLE_ENTRIES(TBL)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Table model
  // -------------------------------------------------------------------------
  function automatic void clear_station_table();
    for (int i = 0; i < TBL; i++) begin
      tbl_mac[i]   = '0;
      tbl_port[i]  = '0;
      tbl_stamp[i] = '0;
      tbl_valid[i] = 1'b0;
    end
    cur_timeout = TIMEOUT_RST;
    cur_enable  = ENABLE_RST;
  endfunction

  function automatic int find_station(logic [MAC_W-1:0] mac);
    for (int i = 0; i < TBL; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // Learn the source, age the destination and form the egress decision
  function automatic out_beat_t decide_frame(in_beat_t f);
    logic [MASK_W-1:0] live;
    logic [TIME_W:0]   expiry;
    int                slot;
    int                outport;
    out_beat_t         d;
    d       = '0;
    outport = -1;
    live    = cur_enable & LIVE_MASK;
    if (!live[f.ingress_port]) begin
      d.verdict = VERD_IN_DISABLED;
      return d;
    end
    if (cur_timeout != '0) begin
      // refresh in place, else take the lowest free slot
      slot = find_station(f.src_mac);
      if (slot < 0) begin
        for (int i = 0; i < TBL && slot < 0; i++)
          if (!tbl_valid[i]) slot = i;
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_mac[slot]   = f.src_mac;
        end
      end
      if (slot < 0) begin
        d.learn_skipped = 1'b1;
      end else begin
        tbl_port[slot]  = f.ingress_port;
        tbl_stamp[slot] = f.arrival_seconds;
      end
      // group destinations never look up the table
      if (!f.dst_mac[GROUP_BIT]) begin
        slot = find_station(f.dst_mac);
        if (slot >= 0) begin
          expiry = {1'b0, tbl_stamp[slot]} + {17'd0, cur_timeout};
          if ({1'b0, f.arrival_seconds} < expiry) outport = tbl_port[slot];
          else tbl_valid[slot] = 1'b0;
        end
      end
    end
    if (outport < 0) begin
      d.egress_mask = live & ~(8'd1 << f.ingress_port);
      d.verdict     = VERD_FLOOD;
    end else if (outport == int'(f.ingress_port)) begin
      d.verdict = VERD_SAME_PORT;
    end else if (!live[outport]) begin
      d.verdict = VERD_OUT_DISABLED;
    end else begin
      d.egress_mask = 8'd1 << outport;
      d.verdict     = VERD_FORWARD;
    end
    return d;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: track register writes, predict on input beats, check output
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AGE_TIMEOUT: cur_timeout = cfg_data;
          REG_PORT_ENABLE: cur_enable  = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_decisions.insert(pending_decisions.size(), decide_frame(in_data));
        frames_sent++;
      end
      if (out_valid && !out_stall) begin
        if (pending_decisions.size() == 0) begin
          $error("decision beat with no frame pending: mask %0h verdict %0d",
                 out_data.egress_mask, out_data.verdict);
          err_cnt++;
        end else begin
          want = pending_decisions.pop_front();
          if (out_data.egress_mask !== want.egress_mask) begin
            $error("egress_mask: expected %0h, got %0h", want.egress_mask,
                   out_data.egress_mask);
            err_cnt++;
          end
          if (out_data.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_data.verdict);
            err_cnt++;
          end
          if (out_data.learn_skipped !== want.learn_skipped) begin
            $error("learn_skipped: expected %0b, got %0b", want.learn_skipped,
                   out_data.learn_skipped);
            err_cnt++;
          end
          case (want.verdict)
            VERD_FORWARD: n_forward++;
            VERD_FLOOD:   n_flood++;
            default:      n_drop++;
          endcase
          if (want.learn_skipped) n_skip++;
        end
      end
    end
  end

  // Receiver: random stall, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  function automatic in_beat_t hdr(logic [PORT_W-1:0] port, logic [MAC_W-1:0] src,
                                   logic [MAC_W-1:0] dst, logic [TIME_W-1:0] t);
    in_beat_t f;
    f.ingress_port    = port;
    f.src_mac         = src;
    f.dst_mac         = dst;
    f.arrival_seconds = t;
    return f;
  endfunction

  // Offer one header, hold it until taken, then maybe go idle
  task automatic send_frame(in_beat_t f);
    in_data  <= f;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every decision has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [TMO_W-1:0] tmo, logic [MASK_W-1:0] mask);
    wait_drained();
    write_reg(REG_AGE_TIMEOUT, tmo);
    write_reg(REG_PORT_ENABLE, {8'd0, mask});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void init_hosts();
    for (int i = 0; i < POOL; i++) begin
      host_mac[i]            = {16'($urandom), 32'($urandom)};
      host_mac[i][GROUP_BIT] = 1'b0;
      host_port[i]           = 3'($urandom_range(7));
    end
    clock_s = 32'($urandom_range(1000));
  endfunction

  // Mostly pool traffic with a moving clock; the rest fully random headers
  function automatic in_beat_t make_traffic_frame(int pool_n);
    in_beat_t          f;
    logic [MAC_W-1:0]  dst;
    int                s;
    int                k;
    if ($urandom_range(99) >= 85) begin
      return hdr(3'($urandom_range(7)), {16'($urandom), 32'($urandom)},
                 {16'($urandom), 32'($urandom)}, 32'($urandom));
    end
    s = $urandom_range(pool_n - 1);
    if ($urandom_range(19) == 0) host_port[s] = 3'($urandom_range(7));
    k = $urandom_range(99);
    if (k < 80) begin
      dst = host_mac[$urandom_range(pool_n - 1)];
    end else if (k < 86) begin
      dst = MAC_BCAST;
    end else if (k < 92) begin
      dst            = {16'($urandom), 32'($urandom)};
      dst[GROUP_BIT] = 1'b1;
    end else begin
      dst            = {16'($urandom), 32'($urandom)};
      dst[GROUP_BIT] = 1'b0;
    end
    k = $urandom_range(99);
    if (k < 85)      clock_s = clock_s + 32'($urandom_range(2));
    else if (k < 95) clock_s = clock_s + 32'($urandom_range(600));
    else if (k < 98) clock_s = clock_s - 32'($urandom_range(1, 5));
    else             clock_s = 32'($urandom);
    f = hdr(host_port[s], host_mac[s], dst, clock_s);
    return f;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_learn_forward();
    send_frame(hdr(3'd0, MAC_A, MAC_B, 32'd0));
    send_frame(hdr(3'd1, MAC_B, MAC_A, 32'd1));
    send_frame(hdr(3'd2, MAC_C, MAC_BCAST, 32'd2));
    send_frame(hdr(3'd3, MAC_D, MAC_GROUP, 32'd3));
    // source equals destination: refreshed entry points back at ingress
    send_frame(hdr(3'd0, MAC_A, MAC_A, 32'd4));
    send_frame(hdr(3'd7, MAC_HI, '0, 32'hFFFF_FFFF));
    send_frame(hdr(3'd1, '0, MAC_B, 32'd5));
    // arrival earlier than the stamp still counts as live
    send_frame(hdr(3'd2, MAC_C, MAC_HI, 32'd6));
  endtask

  task automatic test_aging();
    set_config(16'd10, 8'hFF);
    send_frame(hdr(3'd4, MAC_E, MAC_A, 32'd9));
    send_frame(hdr(3'd4, MAC_E, MAC_A, 32'd14));
    send_frame(hdr(3'd5, MAC_F, MAC_E, 32'd3));
    send_frame(hdr(3'd5, MAC_F, MAC_A, 32'd15));
    // longest lifetime: last live second, then first expired one
    set_config(16'hFFFF, 8'hFF);
    send_frame(hdr(3'd2, MAC_C, MAC_E, 32'd65548));
    send_frame(hdr(3'd3, MAC_D, MAC_E, 32'd65549));
  endtask

  task automatic test_port_mask();
    set_config(16'hFFFF, 8'h7F);
    send_frame(hdr(3'd0, MAC_A, MAC_HI, 32'd20));
    send_frame(hdr(3'd7, MAC_B, MAC_A, 32'd21));
    // only the ingress port enabled: empty flood
    set_config(16'hFFFF, 8'h01);
    send_frame(hdr(3'd0, MAC_A, MAC_BCAST, 32'd22));
    set_config(16'hFFFF, 8'h00);
    send_frame(hdr(3'd0, MAC_A, MAC_B, 32'd23));
  endtask

  task automatic test_hub_mode();
    set_config(16'd0, 8'hFF);
    send_frame(hdr(3'd1, MAC_B, MAC_A, 32'd24));
    send_frame(hdr(3'd6, MAC_C, MAC_E, 32'd25));
    send_frame(hdr(3'd5, MAC_F, MAC_F, 32'd26));
  endtask

  // Fill the table past capacity, then free slots by aging and reuse them
  task automatic test_table_overflow();
    set_config(16'hFFFF, 8'hFF);
    send_idle_pct = 0;
    stall_pct     = 20;
    for (int i = 0; i < POOL; i++)
      send_frame(hdr(host_port[i], host_mac[i], host_mac[$urandom_range(POOL - 1)], clock_s));
    set_config(16'd1, 8'hFF);
    clock_s = clock_s + 32'd10;
    for (int i = 0; i < 24; i++)
      send_frame(hdr(host_port[64 + i], host_mac[64 + i], host_mac[i], clock_s));
  endtask

  // Hold the receiver off while the sender keeps offering beats
  task automatic test_output_backpressure();
    set_config(16'd300, 8'hFF);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 150;
    repeat (64) send_frame(make_traffic_frame(POOL));
    wait_drained();
  endtask

  task automatic test_random_traffic(int n, int snd_idle, int rcv_stall,
                                     logic [TMO_W-1:0] tmo, logic [MASK_W-1:0] mask,
                                     int pool_n);
    set_config(tmo, mask);
    send_idle_pct = snd_idle;
    stall_pct     = rcv_stall;
    for (int i = 0; i < n; i++) begin
      send_frame(make_traffic_frame(pool_n));
      // pause now and then until all decisions are back
      if (i % 128 == 127) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clear_station_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_learn_forward();
    test_aging();
    test_port_mask();
    test_hub_mode();

    init_hosts();
    test_table_overflow();
    test_output_backpressure();
    test_random_traffic(300, 0, 0, 16'd300, 8'hFF, 48);
    test_random_traffic(300, 69, 0, 16'd20, 8'($urandom_range(1, 254)), 96);
    test_random_traffic(300, 0, 69, 16'hFFFF, 8'hFF, 96);
    test_random_traffic(300, 10, 10, 16'd1, 8'hDF, 64);
    test_random_traffic(250, 10, 10, 16'd0, 8'hFF, 96);

    wait_drained();
    if (pending_decisions.size() != 0) begin
      $error("%0d decisions never arrived", pending_decisions.size());
      err_cnt++;
    end
    $display("Covered %0d headers: %0d forwarded, %0d flooded, %0d dropped, %0d unlearned",
             frames_sent, n_forward, n_flood, n_drop, n_skip);
    $display("Settings spanned hub mode, 1 s to 65535 s aging and empty to full port masks");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== learning_bridge_forward_decision.f =====
+incdir+rtl/core
rtl/core/lbfd_pkg.sv
rtl/core/learning_bridge_forward_decision.sv
tb/tb.sv
